// ===== design/ternary_weight_dot_product_macros.svh =====
// ----------------------------------------------------------------------------
// Ternary weight dot product assertion macros
// Shared property wrappers clocked by clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef TERNARY_WEIGHT_DOT_PRODUCT_MACROS_SVH
`define TERNARY_WEIGHT_DOT_PRODUCT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TWDP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TWDP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/twdp_pkg.sv =====
// ----------------------------------------------------------------------------
// Ternary weight dot product package
// Lane count, widths, weight code names and shared types.
// ----------------------------------------------------------------------------
package twdp_pkg;

  localparam int LANES       = 16;
  localparam int INPUT_LANES = 16;
  localparam int ACT_W       = 8;
  localparam int CODE_W      = 2;
  localparam int TERM_W      = ACT_W + 1;
  localparam int CHUNK_W     = TERM_W + $clog2(LANES);
  localparam int SUM_W       = 32;
  localparam int TREE_N      = 1 << $clog2(LANES);
  localparam int WCODE_W     = 32;
  localparam int ACT_BUS_W   = 64;

  localparam logic [CODE_W-1:0] CODE_NEG     = 2'd0;
  localparam logic [CODE_W-1:0] CODE_ZERO    = 2'd1;
  localparam logic [CODE_W-1:0] CODE_POS     = 2'd2;
  localparam logic [CODE_W-1:0] CODE_POS_ALT = 2'd3;

  typedef logic signed [ACT_W-1:0]   act_t;
  typedef logic        [CODE_W-1:0]  code_t;
  typedef logic signed [TERM_W-1:0]  term_t;
  typedef logic signed [CHUNK_W-1:0] chunk_t;
  typedef logic signed [SUM_W-1:0]   sum_t;
  typedef term_t                     term_vec_t [LANES];

  typedef struct packed {
    logic valid;
    logic last;
  } twdp_ctl_t;

endpackage

// ===== design/twdp_in_if.sv =====
// ----------------------------------------------------------------------------
// Ternary weight dot product input channel
// Valid/ready channel carrying one chunk of weights and activations.
// ----------------------------------------------------------------------------
interface twdp_in_if;
  import twdp_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [WCODE_W-1:0]   weight_codes;
  logic [ACT_BUS_W-1:0] act_low;
  logic [ACT_BUS_W-1:0] act_high;
  logic                 last;

  modport source (output valid, output weight_codes, output act_low, output act_high,
                  output last, input ready);
  modport sink   (input valid, input weight_codes, input act_low, input act_high,
                  input last, output ready);
endinterface

// ===== design/twdp_out_if.sv =====
// ----------------------------------------------------------------------------
// Ternary weight dot product output channel
// Valid/ready channel carrying one finished dot product.
// ----------------------------------------------------------------------------
interface twdp_out_if;
  import twdp_pkg::*;

  logic              valid;
  logic              ready;
  logic signed [SUM_W-1:0] dot_sum;

  modport source (output valid, output dot_sum, input ready);
  modport sink   (input valid, input dot_sum, output ready);
endinterface

// ===== design/twdp_lane.sv =====
// ----------------------------------------------------------------------------
// Ternary weight dot product lane
// Applies one ternary weight code to one signed activation.
// ----------------------------------------------------------------------------
module twdp_lane (
  input  twdp_pkg::act_t  act_i,
  input  twdp_pkg::code_t code_i,
  output twdp_pkg::term_t term_o
);
  import twdp_pkg::*;

  term_t act_ext;

  assign act_ext = term_t'(act_i);

  // Negation is taken at nine bits, so an activation of -128 gives +128.
  always_comb begin
    case (code_i)
      CODE_NEG:     term_o = -act_ext;
      CODE_ZERO:    term_o = '0;
      CODE_POS:     term_o = act_ext;
      CODE_POS_ALT: term_o = act_ext;
      default:      term_o = '0;
    endcase
  end
endmodule

// ===== design/twdp_merge.sv =====
// ----------------------------------------------------------------------------
// Ternary weight dot product merge stage
// Adds the lane terms, accumulates the chunk sum and holds the result.
// ----------------------------------------------------------------------------
module twdp_merge (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  twdp_pkg::term_vec_t   terms_i,
  input  twdp_pkg::twdp_ctl_t   ctl_i,
  output logic                  accept_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output twdp_pkg::sum_t        dot_sum_o
);
  import twdp_pkg::*;

  chunk_t node [1:2*TREE_N-1];
  sum_t   acc_q, acc_d;
  sum_t   total;
  sum_t   dot_sum_q, dot_sum_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    for (int i = 0; i < TREE_N; i++) begin
      if (i < LANES) begin
        node[TREE_N + i] = chunk_t'(terms_i[i]);
      end else begin
        node[TREE_N + i] = '0;
      end
    end
    for (int k = TREE_N - 1; k >= 1; k--) begin
      node[k] = node[2*k] + node[2*k + 1];
    end
  end

  assign total    = acc_q + sum_t'(node[1]);
  assign accept_o = ctl_i.valid && (!ctl_i.last || !out_valid_q || out_ready_i);

  always_comb begin
    acc_d       = acc_q;
    dot_sum_d   = dot_sum_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (accept_o) begin
      if (ctl_i.last) begin
        acc_d       = '0;
        dot_sum_d   = total;
        out_valid_d = 1'b1;
      end else begin
        acc_d = total;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dot_sum_q <= dot_sum_d;
  end

  assign out_valid_o = out_valid_q;
  assign dot_sum_o   = dot_sum_q;
endmodule

// ===== design/ternary_weight_dot_product.sv =====
// ----------------------------------------------------------------------------
// Ternary weight dot product
// Streams chunks of sixteen signed bytes against packed ternary weights and
// returns the dot product of each vector.
//
// The input channel takes one chunk per transfer: sixteen two-bit weight
// codes and sixteen activations. The chunk flagged last closes the vector.
// The output channel gives one 32-bit wrapping sum per vector.
// Throughput is one chunk per cycle unless a last chunk waits for the
// output register, set by the parallel lanes and the combinational adder
// tree in the merge stage. A last chunk is registered in the lane stage,
// and its result is then registered in the output register of the merge
// stage, from where it can transfer on the output channel.
// The lane terms are registered in a stage between the lanes and the merge.
// When the receiver stalls, chunks that are not last keep flowing into the
// accumulator; a last chunk waits in the lane stage until the output register
// is free, and while it waits the input takes no chunks.
// Reset clears the accumulator and empties both stages.
// ----------------------------------------------------------------------------
module ternary_weight_dot_product (
  input  logic             clk_i,
  input  logic             rst_ni,
  twdp_in_if.sink          in_i,
  twdp_out_if.source       out_o
);
  import twdp_pkg::*;

  term_t     lane_term [LANES];
  term_vec_t terms_q, terms_d;
  twdp_ctl_t ctl_q, ctl_d;
  logic      accept;
  logic      in_fire;

  for (genvar j = 0; j < LANES; j++) begin : g_lane
    if (j < INPUT_LANES) begin : g_used
      localparam int CodePos = (j / 4) * 8 + 6 - 2 * (j % 4);
      act_t act;
      if (j < 8) begin : g_low
        assign act = in_i.act_low[ACT_W*j +: ACT_W];
      end else begin : g_high
        assign act = in_i.act_high[ACT_W*(j-8) +: ACT_W];
      end
      twdp_lane u_lane (
        .act_i  (act),
        .code_i (in_i.weight_codes[CodePos +: CODE_W]),
        .term_o (lane_term[j])
      );
    end else begin : g_unused
      assign lane_term[j] = '0;
    end
  end

  assign in_i.ready = !ctl_q.valid || accept;
  assign in_fire    = in_i.valid && in_i.ready;

  always_comb begin
    terms_d = terms_q;
    ctl_d   = ctl_q;
    if (in_fire) begin
      terms_d     = lane_term;
      ctl_d.valid = 1'b1;
      ctl_d.last  = in_i.last;
    end else if (accept) begin
      ctl_d.valid = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    terms_q <= terms_d;
  end

  twdp_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .terms_i     (terms_q),
    .ctl_i       (ctl_q),
    .accept_o    (accept),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .dot_sum_o   (out_o.dot_sum)
  );
endmodule

// ===== design/twdp_checker.sv =====
// ----------------------------------------------------------------------------
// Ternary weight dot product checker
// Watches the ports of the top level for handshake and timing slips.
// ----------------------------------------------------------------------------
`include "ternary_weight_dot_product_macros.svh"

module twdp_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_i,
  input logic                  in_last_i,
  input logic                  out_valid_i,
  input logic                  out_ready_i,
  input twdp_pkg::sum_t        dot_sum_i
);
  import twdp_pkg::*;

  `TWDP_ASSERT_NEXT(a_out_valid_hold, out_valid_i && !out_ready_i, out_valid_i, "Result dropped while stalled.")
  `TWDP_ASSERT_NEXT(a_out_data_hold, out_valid_i && !out_ready_i, $stable(dot_sum_i), "Result changed while stalled.")
  `TWDP_ASSERT_SAME(a_in_stall_cause, !in_ready_i, out_valid_i && !out_ready_i, "Input stalled without a stalled result.")
  `TWDP_ASSERT_SAME(a_out_latency, $rose(out_valid_i), $past(in_valid_i && in_ready_i && in_last_i, 2), "Result without a last transfer two cycles before.")
endmodule

bind ternary_weight_dot_product twdp_checker u_twdp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_last_i   (in_i.last),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .dot_sum_i   (out_o.dot_sum)
);
